@@ hdl/rc4_pkg.sv @@
package rc4_pkg;

    // Permutation table geometry
    localparam int TABLE_SIZE    = 256;
    localparam int IDX_W         = $clog2(TABLE_SIZE);
    localparam int BYTE_W        = 8;

    // Key store geometry
    localparam int MAX_KEY_BYTES = 256;
    localparam int KEY_AW        = $clog2(MAX_KEY_BYTES);

    // Key length register
    localparam int KEY_LEN_W     = 9;
    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = KEY_LEN_W'(16);
    localparam logic [KEY_LEN_W-1:0] KEY_LEN_MAX   = KEY_LEN_W'(MAX_KEY_BYTES);

    // Command codes
    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_KEY_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_SCHEDULE  = 2'd1;
    localparam logic [OP_W-1:0] OP_DATA      = 2'd2;

endpackage

@@ hdl/rc4_ram.sv @@
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ hdl/rc4_stream_cipher.sv @@
// Channel   Direction  Handshake             Word
// --------  ---------  --------------------  --------------------------------
// in        sink       in_valid / in_stall   opcode, key_index, value
// out       source     out_valid / out_stall out_byte
// cfg       sink       cfg_valid / cfg_ready key_length
//
// A data byte reads S[i], reads S[j], writes S[i] while reading S[S[i]+S[j]], then
// writes S[j]; the next word is taken in that last cycle, so data bytes stream back
// to back while out is not stalled. Key writes and unused codes leave the block idle.
// A key schedule takes its word, reloads the identity, then runs the swap steps.
// After reset in_stall stays high during the identity load; cfg is always ready.
// A stalled out word holds the block in its last data cycle, with in_stall high.
module rc4_stream_cipher
    import rc4_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [OP_W-1:0]      opcode,
    input  logic [IDX_W-1:0]     key_index,
    input  logic [BYTE_W-1:0]    value,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [BYTE_W-1:0]    out_byte,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [KEY_LEN_W-1:0] key_length
);

    typedef enum logic [2:0] {
        ST_CLEAR,   // sweep identity into the table
        ST_IDLE,    // take a word
        ST_J,       // S[i] arrives, read S[j]
        ST_T,       // S[j] arrives, write S[i], read S[t]
        ST_W,       // write S[j], emit keystream
        ST_KJ,      // schedule: S[k] and key byte arrive, read S[b]
        ST_KW1,     // schedule: write S[k]
        ST_KW2      // schedule: write S[b], read next S[k]
    } state_t;

    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      i_reg, i_next;
    logic [IDX_W-1:0]      j_reg, j_next;
    logic [BYTE_W-1:0]     si_reg, si_next;
    logic [BYTE_W-1:0]     sj_reg, sj_next;
    logic [IDX_W-1:0]      t_reg, t_next;
    logic [BYTE_W-1:0]     val_reg, val_next;
    logic                  hit_reg, hit_next;
    logic                  sched_reg, sched_next;
    logic [KEY_AW-1:0]     kpos_reg, kpos_next;
    logic [KEY_LEN_W-1:0]  klen_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]     out_byte_reg, out_byte_next;

    logic                  perm_we;
    logic [IDX_W-1:0]      perm_wr_addr;
    logic [BYTE_W-1:0]     perm_wr_data;
    logic [IDX_W-1:0]      perm_rd_addr;
    logic [BYTE_W-1:0]     perm_rd_data;
    logic                  key_we;
    logic [BYTE_W-1:0]     key_rd_data;

    logic                  accept;
    logic                  out_ok;
    logic [IDX_W-1:0]      i_plus;
    logic [BYTE_W-1:0]     si_fwd;
    logic [BYTE_W-1:0]     ks;
    logic [KEY_LEN_W-1:0]  len_eff;
    logic                  kpos_wrap;
    logic [IDX_W-1:0]      b_new;
    logic [IDX_W-1:0]      t_new;

    // ---------------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------------
    assign out_ok    = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == ST_IDLE) || ((state_reg == ST_W) && out_ok));
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

    // ---------------------------------------------------------------------
    // Datapath helpers
    // ---------------------------------------------------------------------
    assign i_plus = i_reg + IDX_W'(1);

    // Take S[i] from the pending write of S[j] when the last step wrote it
    assign si_fwd = hit_reg ? si_reg : perm_rd_data;

    // S[t] read overlaps the swap write-back: patch both swapped entries
    always_comb
    begin
        if (t_reg == j_reg)
        begin
            ks = si_reg;
        end
        else if (t_reg == i_reg)
        begin
            ks = sj_reg;
        end
        else
        begin
            ks = perm_rd_data;
        end
    end

    // Clamp key length to 1..MAX_KEY_BYTES
    always_comb
    begin
        if (klen_reg == '0)
        begin
            len_eff = KEY_LEN_W'(1);
        end
        else if (klen_reg > KEY_LEN_MAX)
        begin
            len_eff = KEY_LEN_MAX;
        end
        else
        begin
            len_eff = klen_reg;
        end
    end

    assign kpos_wrap = (KEY_LEN_W'(kpos_reg) + KEY_LEN_W'(1)) >= len_eff;
    assign b_new     = j_reg + si_fwd + key_rd_data;
    assign t_new     = si_reg + perm_rd_data;

    assign key_we = accept && (opcode == OP_KEY_WRITE)
                    && ({1'b0, key_index} < (IDX_W + 1)'(MAX_KEY_BYTES));

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        si_next        = si_reg;
        sj_next        = sj_reg;
        t_next         = t_reg;
        val_next       = val_reg;
        hit_next       = hit_reg;
        sched_next     = sched_reg;
        kpos_next      = kpos_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;

        perm_we        = 1'b0;
        perm_wr_addr   = i_reg;
        perm_wr_data   = si_reg;
        perm_rd_addr   = i_plus;

        // Drop the out word once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                perm_we      = 1'b1;
                perm_wr_addr = i_reg;
                perm_wr_data = BYTE_W'(i_reg);
                i_next       = i_plus;
                // Last sweep write also reads S[0] for the first swap step
                if (i_reg == IDX_W'(TABLE_SIZE - 1))
                begin
                    state_next = sched_reg ? ST_KJ : ST_IDLE;
                    sched_next = 1'b0;
                    hit_next   = 1'b0;
                end
            end

            ST_IDLE:
            begin
            end

            ST_J:
            begin
                si_next      = si_fwd;
                j_next       = j_reg + si_fwd;
                perm_rd_addr = j_reg + si_fwd;
                state_next   = ST_T;
            end

            ST_T:
            begin
                sj_next      = perm_rd_data;
                perm_we      = 1'b1;
                perm_wr_addr = i_reg;
                perm_wr_data = perm_rd_data;
                perm_rd_addr = t_new;
                t_next       = t_new;
                state_next   = ST_W;
            end

            ST_W:
            begin
                perm_we      = 1'b1;
                perm_wr_addr = j_reg;
                perm_wr_data = si_reg;
                // Hold the S[t] read while the out register is full
                perm_rd_addr = t_reg;
                if (out_ok)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = val_reg ^ ks;
                    state_next     = ST_IDLE;
                end
            end

            ST_KJ:
            begin
                si_next      = si_fwd;
                j_next       = b_new;
                perm_rd_addr = b_new;
                kpos_next    = kpos_wrap ? '0 : kpos_reg + KEY_AW'(1);
                state_next   = ST_KW1;
            end

            ST_KW1:
            begin
                perm_we      = 1'b1;
                perm_wr_addr = i_reg;
                perm_wr_data = perm_rd_data;
                state_next   = ST_KW2;
            end

            ST_KW2:
            begin
                perm_we      = 1'b1;
                perm_wr_addr = j_reg;
                perm_wr_data = si_reg;
                i_next       = i_plus;
                if (i_reg == IDX_W'(TABLE_SIZE - 1))
                begin
                    // i wraps to zero; clear j to finish the schedule
                    j_next     = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    hit_next   = (i_plus == j_reg);
                    state_next = ST_KJ;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (accept)
        begin
            unique case (opcode)
                OP_SCHEDULE:
                begin
                    state_next = ST_CLEAR;
                    sched_next = 1'b1;
                    i_next     = '0;
                    j_next     = '0;
                    kpos_next  = '0;
                end
                OP_DATA:
                begin
                    perm_rd_addr = i_plus;
                    i_next       = i_plus;
                    val_next     = value;
                    // Next S[i] may be the entry written back this cycle
                    hit_next     = (state_reg == ST_W) && (i_plus == j_reg);
                    state_next   = ST_J;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            i_reg         <= '0;
            j_reg         <= '0;
            hit_reg       <= 1'b0;
            sched_reg     <= 1'b0;
            kpos_reg      <= '0;
            klen_reg      <= KEY_LEN_RESET;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            hit_reg       <= hit_next;
            sched_reg     <= sched_next;
            kpos_reg      <= kpos_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            if (cfg_valid && cfg_ready)
            begin
                klen_reg <= key_length;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        si_reg       <= si_next;
        sj_reg       <= sj_next;
        t_reg        <= t_next;
        val_reg      <= val_next;
    end

    // ---------------------------------------------------------------------
    // Memories
    // ---------------------------------------------------------------------
    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TABLE_SIZE)
    ) u_perm_ram (
        .clk     (clk),
        .wr_en   (perm_we),
        .wr_addr (perm_wr_addr),
        .wr_data (perm_wr_data),
        .rd_addr (perm_rd_addr),
        .rd_data (perm_rd_data)
    );

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_KEY_BYTES)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (key_we),
        .wr_addr (key_index[KEY_AW-1:0]),
        .wr_data (value),
        .rd_addr (kpos_reg),
        .rd_data (key_rd_data)
    );

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_out_from_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_W))
        else $error("out word raised outside the write-back cycle");

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR || state_reg == ST_KJ || state_reg == ST_KW1 ||
         state_reg == ST_KW2 || state_reg == ST_J || state_reg == ST_T) |-> in_stall)
        else $error("word taken while the table port is busy");

    a_sched_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_KW2 && i_reg == IDX_W'(TABLE_SIZE - 1)) |=>
        (i_reg == '0 && j_reg == '0 && state_reg == ST_IDLE))
        else $error("counters not cleared at end of key schedule");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !perm_we)
        else $error("table written while idle");

endmodule
